>>> src/gcl_pkg.sv
// Shared types and constants for the GCD / LCM unit.
package gcl_pkg;

  localparam int DATA_WIDTH = 31;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int ALU_W      = DATA_WIDTH + 2;

  localparam logic [DATA_WIDTH-1:0] DATA_MAX = {DATA_WIDTH{1'b1}};

  typedef struct packed {
    logic [DATA_WIDTH-1:0] operand_a;
    logic [DATA_WIDTH-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] gcd_value;
    logic [DATA_WIDTH-1:0] lcm_value;
    logic                  lcm_overflow;
  } rsp_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALIGN,
    S_REDUCE,
    S_DIV,
    S_MUL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_status_t;

endpackage

>>> src/gcl_alu.sv
// Shared adder/subtractor for the reduce, divide and multiply steps.
module gcl_alu (
  input  gcl_pkg::alu_op_t                 op,
  input  logic [gcl_pkg::DATA_WIDTH:0]     x,
  input  logic [gcl_pkg::DATA_WIDTH-1:0]   y,
  output logic [gcl_pkg::ALU_W-1:0]        res
);
  import gcl_pkg::*;

  logic [ALU_W-1:0] xe;
  logic [ALU_W-1:0] ye;

  assign xe = {1'b0, x};
  assign ye = {2'b00, y};

  always_comb begin
    unique case (op)
      ALU_ADD: res = xe + ye;
      ALU_SUB: res = xe - ye;
      default: res = xe;
    endcase
  end

endmodule

>>> src/gcl_engine.sv
// Sequencer and datapath: binary GCD, restoring divide, shift-add multiply.
module gcl_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  gcl_pkg::req_t        req,
  input  logic                 take,
  output gcl_pkg::eng_status_t status,
  output gcl_pkg::rsp_t        rsp
);
  import gcl_pkg::*;

  state_t                state, state_next;
  logic [DATA_WIDTH-1:0] u, u_next;
  logic [DATA_WIDTH-1:0] v, v_next;
  logic [DATA_WIDTH-1:0] g, g_next;
  logic [DATA_WIDTH-1:0] quo, quo_next;
  logic [DATA_WIDTH-1:0] mpl, mpl_next;
  logic [DATA_WIDTH-1:0] rem, rem_next;
  logic [DATA_WIDTH-1:0] acc, acc_next;
  logic                  ovf, ovf_next;
  logic [CNT_W-1:0]      k, k_next;
  logic [CNT_W-1:0]      cnt, cnt_next;

  alu_op_t               alu_op;
  logic [DATA_WIDTH:0]   alu_x;
  logic [DATA_WIDTH-1:0] alu_y;
  logic [ALU_W-1:0]      alu_res;

  logic                  u_gt;
  logic [DATA_WIDTH:0]   rem_sh;
  logic                  qbit;
  logic                  cnt_last;

  gcl_alu u_alu (
    .op  (alu_op),
    .x   (alu_x),
    .y   (alu_y),
    .res (alu_res)
  );

  assign u_gt     = u > v;
  assign rem_sh   = {rem, quo[DATA_WIDTH-1]};
  assign qbit     = ~alu_res[ALU_W-1];
  assign cnt_last = cnt == CNT_W'(DATA_WIDTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    u   <= u_next;
    v   <= v_next;
    g   <= g_next;
    quo <= quo_next;
    mpl <= mpl_next;
    rem <= rem_next;
    acc <= acc_next;
    ovf <= ovf_next;
    k   <= k_next;
    cnt <= cnt_next;
  end

  always_comb begin
    state_next = state;
    u_next     = u;
    v_next     = v;
    g_next     = g;
    quo_next   = quo;
    mpl_next   = mpl;
    rem_next   = rem;
    acc_next   = acc;
    ovf_next   = ovf;
    k_next     = k;
    cnt_next   = cnt;
    alu_op     = ALU_ADD;
    alu_x      = '0;
    alu_y      = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          u_next     = req.operand_a;
          v_next     = req.operand_b;
          quo_next   = req.operand_a;
          mpl_next   = req.operand_b;
          k_next     = '0;
          state_next = S_ALIGN;
        end
      end

      S_ALIGN: begin
        if (u == '0 || v == '0) begin
          g_next     = u | v;
          acc_next   = '0;
          ovf_next   = 1'b0;
          state_next = S_DONE;
        end else if (!u[0] && !v[0]) begin
          u_next = u >> 1;
          v_next = v >> 1;
          k_next = k + 1'b1;
        end else begin
          state_next = S_REDUCE;
        end
      end

      S_REDUCE: begin
        alu_op = ALU_SUB;
        alu_x  = {1'b0, (u_gt ? u : v)};
        alu_y  = u_gt ? v : u;
        if (u == v) begin
          g_next     = u << k;
          rem_next   = '0;
          cnt_next   = '0;
          state_next = S_DIV;
        end else if (!u[0]) begin
          u_next = u >> 1;
        end else if (!v[0]) begin
          v_next = v >> 1;
        end else if (u_gt) begin
          u_next = {1'b0, alu_res[DATA_WIDTH-1:1]};
        end else begin
          v_next = {1'b0, alu_res[DATA_WIDTH-1:1]};
        end
      end

      S_DIV: begin
        alu_op   = ALU_SUB;
        alu_x    = rem_sh;
        alu_y    = g;
        rem_next = qbit ? alu_res[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
        quo_next = {quo[DATA_WIDTH-2:0], qbit};
        cnt_next = cnt + 1'b1;
        if (cnt_last) begin
          cnt_next   = '0;
          acc_next   = '0;
          ovf_next   = 1'b0;
          state_next = S_MUL;
        end
      end

      S_MUL: begin
        alu_op   = ALU_ADD;
        alu_x    = {acc, 1'b0};
        alu_y    = mpl[DATA_WIDTH-1] ? quo : '0;
        mpl_next = mpl << 1;
        cnt_next = cnt + 1'b1;
        if (!ovf) begin
          if (alu_res > {2'b00, DATA_MAX}) begin
            ovf_next = 1'b1;
          end else begin
            acc_next = alu_res[DATA_WIDTH-1:0];
          end
        end
        if (cnt_last) begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  assign status.idle       = state == S_IDLE;
  assign status.done       = state == S_DONE;
  assign rsp.gcd_value     = g;
  assign rsp.lcm_value     = ovf ? DATA_MAX : acc;
  assign rsp.lcm_overflow  = ovf;

endmodule

>>> src/gcd_lcm_unit.sv
// Top level of the GCD / LCM unit: request handshake and result register.
// Each request carries two unsigned 31-bit operands and returns one result with
// their greatest common divisor, least common multiple and an overflow flag
// (multiple saturated to all ones). One shared adder/subtractor does all the
// work under a sequencer, so a request is taken only while the engine is idle.
// A request runs c alignment steps, c being the number of common factors of
// two (at most 30), then r binary-GCD reduction steps (at most about 2*31),
// then 31 divide steps for a/gcd and 31 multiply steps for the multiple.
// With either operand zero it goes from the alignment check to the result.
// A finished result waits in the output register while the next request runs.
module gcd_lcm_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  gcl_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_ready,
  output gcl_pkg::rsp_t out_rsp
);
  import gcl_pkg::*;

  eng_status_t status;
  rsp_t        eng_rsp;
  logic        take;

  gcl_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (in_valid),
    .req    (in_req),
    .take   (take),
    .status (status),
    .rsp    (eng_rsp)
  );

  assign in_ready = status.idle;
  assign take     = status.done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_rsp <= eng_rsp;
    end
  end

endmodule

>>> src/gcl_checker.sv
// Port-level assertions for the GCD / LCM unit, bound to the top level.
module gcl_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input gcl_pkg::rsp_t out_rsp
);
  import gcl_pkg::*;

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("unit ready right after taking a request");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed or dropped");

  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.lcm_overflow |-> out_rsp.lcm_value == DATA_MAX)
    else $error("overflow without saturated multiple");

  a_zero_gcd: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.gcd_value == '0 |->
      out_rsp.lcm_value == '0 && !out_rsp.lcm_overflow)
    else $error("zero gcd with nonzero multiple");

endmodule

bind gcd_lcm_unit gcl_checker u_gcl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_rsp   (out_rsp)
);

>>> dv/testbench.sv
// Self-checking testbench for gcd_lcm_unit: directed and random operand pairs.
`timescale 1ns / 100ps

module testbench;
  import gcl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned HOLD_CYCLES = 2500;
  localparam int unsigned RANDOM_PAIRS = 500;
  localparam int unsigned DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_rsp;

  req_t operand_pairs[$];
  rsp_t pending_gcd_lcm[$];
  rsp_t want_rsp;

  logic req_fire = 1'b0;
  logic rsp_fire = 1'b0;
  logic steady = 1'b0;
  logic backpressure_done = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned pair_total = 0;
  int unsigned pairs_sent = 0;
  int unsigned results_checked = 0;
  int unsigned zero_operand_count = 0;
  int unsigned overflow_count = 0;
  int unsigned error_count = 0;

  gcd_lcm_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Euclid remainder loop, then (a / gcd) * b saturated to DATA_MAX.
  function automatic rsp_t gcd_lcm_of(req_t r);
    logic [63:0] x, y, t, q, m;
    rsp_t res;
    x = 64'(r.operand_a);
    y = 64'(r.operand_b);
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    res.gcd_value = x[DATA_WIDTH-1:0];
    res.lcm_value = '0;
    res.lcm_overflow = 1'b0;
    if (r.operand_a != 0 && r.operand_b != 0) begin
      q = 64'(r.operand_a) / x;
      m = q * 64'(r.operand_b);
      if (m > 64'(DATA_MAX)) begin
        res.lcm_value = DATA_MAX;
        res.lcm_overflow = 1'b1;
      end else begin
        res.lcm_value = m[DATA_WIDTH-1:0];
      end
    end
    return res;
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(60, 300);
  endfunction

  task automatic queue_pair(logic [63:0] a, logic [63:0] b);
    req_t r;
    r.operand_a = a[DATA_WIDTH-1:0];
    r.operand_b = b[DATA_WIDTH-1:0];
    operand_pairs.push_back(r);
    pair_total++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count[9:0] == 0) begin
      steady <= ($urandom_range(0, 3) == 0);
    end
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d of %0d results seen",
               $time, cycle_count, results_checked, pair_total);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // request side
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_fire) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (operand_pairs.size() != 0) begin
        in_valid <= 1'b1;
        in_req <= operand_pairs.pop_front();
        send_gap <= idle_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side, with one long hold-off so the unit backs up into the request side
  always @(negedge clk) begin : drive_ready
    int unsigned n;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!backpressure_done && pairs_sent >= 40) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      backpressure_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rsp_fire || $urandom_range(0, 15) == 0) begin
      n = idle_gap();
      out_ready <= (n == 0);
      stall_left <= (n == 0) ? 0 : n - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    req_fire <= !rst && in_valid && in_ready;
    rsp_fire <= !rst && out_valid && out_ready;
    if (!rst && in_valid && in_ready) begin
      pending_gcd_lcm.push_back(gcd_lcm_of(in_req));
      pairs_sent <= pairs_sent + 1;
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_gcd_lcm.size() == 0) begin
        $display("%0t: result with no request pending: gcd %0d lcm %0d ovf %0b",
                 $time, out_rsp.gcd_value, out_rsp.lcm_value, out_rsp.lcm_overflow);
        error_count++;
      end else begin
        want_rsp = pending_gcd_lcm.pop_front();
        results_checked++;
        if (want_rsp.lcm_overflow) overflow_count++;
        if (want_rsp.lcm_value == 0) zero_operand_count++;
        if (out_rsp.gcd_value !== want_rsp.gcd_value) begin
          $display("%0t: gcd_value mismatch: expected %0d, actual %0d",
                   $time, want_rsp.gcd_value, out_rsp.gcd_value);
          error_count++;
        end
        if (out_rsp.lcm_value !== want_rsp.lcm_value) begin
          $display("%0t: lcm_value mismatch: expected %0d, actual %0d",
                   $time, want_rsp.lcm_value, out_rsp.lcm_value);
          error_count++;
        end
        if (out_rsp.lcm_overflow !== want_rsp.lcm_overflow) begin
          $display("%0t: lcm_overflow mismatch: expected %0b, actual %0b",
                   $time, want_rsp.lcm_overflow, out_rsp.lcm_overflow);
          error_count++;
        end
      end
    end
  end

  initial begin
    logic [63:0] a, b, g;
    int unsigned kind, sh;

    // zeros, ones, full scale, saturation edge, long Euclid chains
    queue_pair(0, 0);
    queue_pair(0, DATA_MAX);
    queue_pair(DATA_MAX, 0);
    queue_pair(0, 1);
    queue_pair(1, 0);
    queue_pair(1, 1);
    queue_pair(DATA_MAX, DATA_MAX);
    queue_pair(DATA_MAX, DATA_MAX - 1);
    queue_pair(DATA_MAX, 1);
    queue_pair(1, DATA_MAX);
    queue_pair(64'd1 << 30, 64'd1 << 30);
    queue_pair(64'd1 << 30, 2);
    queue_pair(64'd1 << 30, 3);
    queue_pair(64'd1 << 30, 64'd1 << 15);
    queue_pair(46341, 46341);
    queue_pair(46340, 46341);
    queue_pair(46341, 46342);
    queue_pair(1836311903, 1134903170);
    queue_pair(1134903170, 1836311903);
    queue_pair(31'h2AAAAAAA, 31'h55555555);
    queue_pair(3 * 65521, 5 * 65521);
    queue_pair(12, 18);
    queue_pair(1000000007, 998244353);

    for (int unsigned i = 0; i < RANDOM_PAIRS; i++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          a = $urandom();
          b = $urandom();
        end
        3: begin
          a = $urandom_range(1, 1000);
          b = $urandom_range(1, 1000);
        end
        4, 5: begin
          g = $urandom_range(1, 65536);
          a = g * $urandom_range(0, 32767);
          b = g * $urandom_range(0, 32767);
        end
        6: begin
          a = $urandom_range(40000, 60000);
          b = $urandom_range(40000, 60000);
        end
        7: begin
          sh = $urandom_range(0, 30);
          a = 64'd1 << sh;
          b = 64'($urandom()) >> $urandom_range(0, 30);
        end
        8: begin
          a = ($urandom_range(0, 7) == 0) ? 0 : 64'($urandom());
          b = 0;
          if ($urandom_range(0, 1) == 1) begin
            b = a;
            a = 0;
          end
        end
        default: begin
          a = $urandom_range(1, 1 << 20);
          b = a * $urandom_range(1, 2047);
        end
      endcase
      queue_pair(a, b);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (results_checked != pair_total) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d operand pairs (%0d directed): %0d zero multiples, %0d saturated",
             results_checked, pair_total - RANDOM_PAIRS, zero_operand_count, overflow_count);
    $display("Output held off %0d cycles once with requests still offered; %0d cycles run",
             HOLD_CYCLES, cycle_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
